/* design/pfrr_pkg.sv */
package pfrr_pkg;

   localparam logic [1:0] OP_ADD_DEFAULT = 2'd0;
   localparam logic [1:0] OP_ADD_DEST    = 2'd1;
   localparam logic [1:0] OP_ASSIGN      = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_TAG   = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_WEIGHT   = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   localparam logic [31:0] LFSR_SEED = 32'hACE1_ACE1;
   localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

   typedef logic [31:0] word_type;

   function automatic word_type lfsr_next(input word_type v);
      word_type r;
      r = {1'b0, v[31:1]};
      if (v[0]) begin
         r = r ^ LFSR_TAPS;
      end
      return r;
   endfunction

endpackage

/* design/per_flow_round_robin_path_assign_top.sv */
// Channel   Ports                              Handshake
// request   req_* fields                       start high while busy low
// response  rsp_status, rsp_path_valid, ...    rsp_valid strobe, one cycle
// config    csr_wdata (mode)                   csr_we, written at once
//
// Each request runs alone through one sequencer; busy stays high until its
// response strobe. A default add appends weight entries, stopping early when
// the list fills. Destination adds and assigns first scan the key memories,
// comparing each used entry; a new destination list copies the default list
// entry by entry, and a new flow waits for the modulo unit. Reset is
// synchronous, clears counts and valid bits, selects flow id keying and
// reloads the LFSR seed; the response side cannot stall.
module per_flow_round_robin_path_assign_top #(
   parameter int PATH_SLOTS   = 64,
   parameter int DEST_ENTRIES = 16,
   parameter int FLOW_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_path_id,
   input  logic [6:0]  req_weight,
   input  logic [31:0] req_dest_addr,
   input  logic [31:0] req_flow_id,
   input  logic        req_has_flow_tag,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic        rsp_path_valid,
   output logic [31:0] rsp_assigned_path,
   input  logic        csr_we,
   input  logic        csr_wdata
);

   localparam int IW  = PATH_SLOTS > 1 ? $clog2(PATH_SLOTS) : 1;
   localparam int CW  = $clog2(PATH_SLOTS + 1);
   localparam int DAW = DEST_ENTRIES > 1 ? $clog2(DEST_ENTRIES) : 1;
   localparam int DCW = $clog2(DEST_ENTRIES + 1);
   localparam int FAW = FLOW_ENTRIES > 1 ? $clog2(FLOW_ENTRIES) : 1;
   localparam int FCW = $clog2(FLOW_ENTRIES + 1);
   localparam int LD  = DEST_ENTRIES * PATH_SLOTS;
   localparam int LAW = LD > 1 ? $clog2(LD) : 1;

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_DISP = 5'd1;
   localparam logic [4:0] S_DREQ = 5'd2;
   localparam logic [4:0] S_DCMP = 5'd3;
   localparam logic [4:0] S_DEND = 5'd4;
   localparam logic [4:0] S_CPRD = 5'd5;
   localparam logic [4:0] S_CPWR = 5'd6;
   localparam logic [4:0] S_APP  = 5'd7;
   localparam logic [4:0] S_FREQ = 5'd8;
   localparam logic [4:0] S_FCMP = 5'd9;
   localparam logic [4:0] S_FEND = 5'd10;
   localparam logic [4:0] S_NXWT = 5'd11;
   localparam logic [4:0] S_DIV  = 5'd12;
   localparam logic [4:0] S_LRD  = 5'd13;
   localparam logic [4:0] S_LWT  = 5'd14;
   localparam logic [4:0] S_DONE = 5'd15;

   logic [4:0]  state_ff, state_in;
   logic        mode_ff, mode_in;
   logic [31:0] lfsr_ff, lfsr_in;
   logic [CW-1:0] defcnt_ff, defcnt_in;
   logic [CW-1:0] dcnt_ff [DEST_ENTRIES];
   logic [CW-1:0] dcnt_in [DEST_ENTRIES];
   logic [DEST_ENTRIES-1:0] dused_ff, dused_in;
   logic [FLOW_ENTRIES-1:0] fused_ff, fused_in;

   logic [1:0]  op_ff, op_in;
   logic [31:0] path_ff, path_in;
   logic [6:0]  weight_ff, weight_in;
   logic [31:0] dest_ff, dest_in;
   logic [31:0] key_ff, key_in;
   logic [DCW-1:0] dscan_ff, dscan_in;
   logic        dhit_ff, dhit_in;
   logic [DAW-1:0] didx_ff, didx_in;
   logic        dfok_ff, dfok_in;
   logic [DAW-1:0] dfree_ff, dfree_in;
   logic [FCW-1:0] fscan_ff, fscan_in;
   logic        fhit_ff, fhit_in;
   logic [FAW-1:0] fidx_ff, fidx_in;
   logic        ffok_ff, ffok_in;
   logic [FAW-1:0] ffree_ff, ffree_in;
   logic        fok_ff, fok_in;
   logic        lsel_ff, lsel_in;
   logic [CW-1:0] wcnt_ff, wcnt_in;
   logic [CW-1:0] cp_ff, cp_in;
   logic [6:0]  k_ff, k_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic        rvalid_ff, rvalid_in;
   logic [2:0]  status_ff, status_in;
   logic        pvalid_ff, pvalid_in;
   logic [31:0] apath_ff, apath_in;

   logic          dl_we, dk_we, fk_we, fn_we, df_we;
   logic [IW-1:0] df_waddr, df_raddr;
   logic [31:0]   df_rdata;
   logic [LAW-1:0] dl_waddr, dl_raddr;
   logic [31:0]   dl_wdata, dl_rdata;
   logic [DAW-1:0] dk_raddr;
   logic [31:0]   dk_rdata;
   logic [FAW-1:0] fk_raddr, fn_raddr;
   logic [31:0]   fk_rdata;
   logic [IW-1:0] fn_wdata, fn_rdata;
   logic          div_start, div_done;
   logic [IW-1:0] div_rem;
   logic [31:0]   lfsr_adv;
   logic [CW-1:0] sel_cnt, idx_inc;
   logic [LAW-1:0] dbase;

   assign lfsr_adv = pfrr_pkg::lfsr_next(lfsr_ff);
   assign sel_cnt  = dhit_ff ? dcnt_ff[didx_ff] : defcnt_ff;
   assign idx_inc  = CW'(idx_ff) + CW'(1);
   assign dbase    = LAW'(didx_ff) * LAW'(PATH_SLOTS);

   pfrr_ram #(.WIDTH(32), .DEPTH(PATH_SLOTS)) u_default_list (
      .clock(clock), .we(df_we), .waddr(df_waddr), .wdata(path_ff),
      .raddr(df_raddr), .rdata(df_rdata));

   pfrr_ram #(.WIDTH(32), .DEPTH(LD)) u_dest_lists (
      .clock(clock), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
      .raddr(dl_raddr), .rdata(dl_rdata));

   pfrr_ram #(.WIDTH(32), .DEPTH(DEST_ENTRIES)) u_dest_keys (
      .clock(clock), .we(dk_we), .waddr(dfree_ff), .wdata(dest_ff),
      .raddr(dk_raddr), .rdata(dk_rdata));

   pfrr_ram #(.WIDTH(32), .DEPTH(FLOW_ENTRIES)) u_flow_keys (
      .clock(clock), .we(fk_we), .waddr(ffree_ff), .wdata(key_ff),
      .raddr(fk_raddr), .rdata(fk_rdata));

   pfrr_ram #(.WIDTH(IW), .DEPTH(FLOW_ENTRIES)) u_flow_next (
      .clock(clock), .we(fn_we), .waddr(fidx_ff), .wdata(fn_wdata),
      .raddr(fn_raddr), .rdata(fn_rdata));

   pfrr_mod #(.CW(CW), .IW(IW)) u_mod (
      .clock(clock), .reset(reset), .start(div_start), .dividend(lfsr_adv),
      .divisor(wcnt_ff), .done(div_done), .remainder(div_rem));

   always_comb begin
      state_in  = state_ff;
      mode_in   = csr_we ? csr_wdata : mode_ff;
      lfsr_in   = lfsr_ff;
      defcnt_in = defcnt_ff;
      dcnt_in   = dcnt_ff;
      dused_in  = dused_ff;
      fused_in  = fused_ff;
      op_in     = op_ff;
      path_in   = path_ff;
      weight_in = weight_ff;
      dest_in   = dest_ff;
      key_in    = key_ff;
      dscan_in  = dscan_ff;
      dhit_in   = dhit_ff;
      didx_in   = didx_ff;
      dfok_in   = dfok_ff;
      dfree_in  = dfree_ff;
      fscan_in  = fscan_ff;
      fhit_in   = fhit_ff;
      fidx_in   = fidx_ff;
      ffok_in   = ffok_ff;
      ffree_in  = ffree_ff;
      fok_in    = fok_ff;
      lsel_in   = lsel_ff;
      wcnt_in   = wcnt_ff;
      cp_in     = cp_ff;
      k_in      = k_ff;
      idx_in    = idx_ff;
      rvalid_in = 1'b0;
      status_in = status_ff;
      pvalid_in = pvalid_ff;
      apath_in  = apath_ff;
      df_we     = 1'b0;
      df_waddr  = IW'(wcnt_ff);
      df_raddr  = '0;
      dl_we     = 1'b0;
      dl_waddr  = dbase + LAW'(wcnt_ff);
      dl_wdata  = path_ff;
      dl_raddr  = '0;
      dk_we     = 1'b0;
      dk_raddr  = dscan_ff[DAW-1:0];
      fk_we     = 1'b0;
      fk_raddr  = fscan_ff[FAW-1:0];
      fn_we     = 1'b0;
      fn_raddr  = fidx_ff;
      fn_wdata  = (idx_inc == wcnt_ff) ? '0 : IW'(idx_inc);
      div_start = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = req_operation;
               path_in   = req_path_id;
               weight_in = req_weight;
               dest_in   = req_dest_addr;
               key_in    = mode_ff ? req_flow_id : req_dest_addr;
               status_in = pfrr_pkg::ST_OK;
               pvalid_in = 1'b0;
               apath_in  = '0;
               state_in  = S_DISP;
               if (mode_ff && !req_has_flow_tag
                   && req_operation == pfrr_pkg::OP_ASSIGN) begin
                  status_in = pfrr_pkg::ST_NO_TAG;
                  state_in  = S_DONE;
               end
            end
         end
         S_DISP: begin
            dscan_in = '0;
            dhit_in  = 1'b0;
            dfok_in  = 1'b0;
            k_in     = '0;
            case (op_ff)
               pfrr_pkg::OP_ADD_DEFAULT: begin
                  if (weight_ff != 7'd1 && !mode_ff) begin
                     status_in = pfrr_pkg::ST_WEIGHT;
                     state_in  = S_DONE;
                  end else begin
                     lsel_in  = 1'b0;
                     wcnt_in  = defcnt_ff;
                     state_in = S_APP;
                  end
               end
               pfrr_pkg::OP_ADD_DEST, pfrr_pkg::OP_ASSIGN: state_in = S_DREQ;
               default: state_in = S_DONE;
            endcase
         end
         S_DREQ: begin
            if (dscan_ff == DCW'(DEST_ENTRIES)) begin
               state_in = S_DEND;
            end else if (dused_ff[dscan_ff[DAW-1:0]]) begin
               state_in = S_DCMP;
            end else begin
               if (!dfok_ff) begin
                  dfok_in  = 1'b1;
                  dfree_in = dscan_ff[DAW-1:0];
               end
               dscan_in = dscan_ff + DCW'(1);
            end
         end
         S_DCMP: begin
            if (dk_rdata == dest_ff) begin
               dhit_in  = 1'b1;
               didx_in  = dscan_ff[DAW-1:0];
               state_in = S_DEND;
            end else begin
               dscan_in = dscan_ff + DCW'(1);
               state_in = S_DREQ;
            end
         end
         S_DEND: begin
            if (op_ff == pfrr_pkg::OP_ADD_DEST) begin
               if (dhit_ff) begin
                  lsel_in  = 1'b1;
                  wcnt_in  = dcnt_ff[didx_ff];
                  state_in = S_APP;
               end else if (dfok_ff) begin
                  dused_in[dfree_ff] = 1'b1;
                  dk_we    = 1'b1;
                  didx_in  = dfree_ff;
                  cp_in    = '0;
                  state_in = S_CPRD;
               end else begin
                  status_in = pfrr_pkg::ST_FULL;
                  state_in  = S_DONE;
               end
            end else begin
               lsel_in = dhit_ff;
               wcnt_in = sel_cnt;
               if (sel_cnt == '0) begin
                  status_in = pfrr_pkg::ST_EMPTY;
                  state_in  = S_DONE;
               end else begin
                  fscan_in = '0;
                  fhit_in  = 1'b0;
                  ffok_in  = 1'b0;
                  state_in = S_FREQ;
               end
            end
         end
         S_CPRD: begin
            df_raddr = IW'(cp_ff);
            if (cp_ff == defcnt_ff) begin
               dcnt_in[didx_ff] = defcnt_ff;
               lsel_in  = 1'b1;
               wcnt_in  = defcnt_ff;
               state_in = S_APP;
            end else begin
               state_in = S_CPWR;
            end
         end
         S_CPWR: begin
            dl_we    = 1'b1;
            dl_waddr = dbase + LAW'(cp_ff);
            dl_wdata = df_rdata;
            cp_in    = cp_ff + CW'(1);
            state_in = S_CPRD;
         end
         S_APP: begin
            if (k_ff == weight_ff) begin
               state_in = S_DONE;
            end else if (wcnt_ff == CW'(PATH_SLOTS)) begin
               status_in = pfrr_pkg::ST_FULL;
               state_in  = S_DONE;
            end else begin
               wcnt_in = wcnt_ff + CW'(1);
               k_in    = k_ff + 7'd1;
               if (lsel_ff) begin
                  dl_we            = 1'b1;
                  dcnt_in[didx_ff] = wcnt_ff + CW'(1);
               end else begin
                  df_we     = 1'b1;
                  defcnt_in = wcnt_ff + CW'(1);
               end
            end
         end
         S_FREQ: begin
            if (fscan_ff == FCW'(FLOW_ENTRIES)) begin
               state_in = S_FEND;
            end else if (fused_ff[fscan_ff[FAW-1:0]]) begin
               state_in = S_FCMP;
            end else begin
               if (!ffok_ff) begin
                  ffok_in  = 1'b1;
                  ffree_in = fscan_ff[FAW-1:0];
               end
               fscan_in = fscan_ff + FCW'(1);
            end
         end
         S_FCMP: begin
            if (fk_rdata == key_ff) begin
               fhit_in  = 1'b1;
               fidx_in  = fscan_ff[FAW-1:0];
               state_in = S_FEND;
            end else begin
               fscan_in = fscan_ff + FCW'(1);
               state_in = S_FREQ;
            end
         end
         S_FEND: begin
            if (fhit_ff) begin
               fok_in   = 1'b1;
               state_in = S_NXWT;
            end else begin
               lfsr_in   = lfsr_adv;
               div_start = 1'b1;
               state_in  = S_DIV;
               if (ffok_ff) begin
                  fused_in[ffree_ff] = 1'b1;
                  fk_we   = 1'b1;
                  fidx_in = ffree_ff;
                  fok_in  = 1'b1;
               end else begin
                  fok_in    = 1'b0;
                  status_in = pfrr_pkg::ST_FULL;
               end
            end
         end
         S_NXWT: begin
            idx_in   = (CW'(fn_rdata) >= wcnt_ff) ? '0 : fn_rdata;
            state_in = S_LRD;
         end
         S_DIV: begin
            if (div_done) begin
               idx_in   = div_rem;
               state_in = S_LRD;
            end
         end
         S_LRD: begin
            df_raddr = idx_ff;
            dl_raddr = dbase + LAW'(idx_ff);
            state_in = S_LWT;
         end
         S_LWT: begin
            apath_in  = lsel_ff ? dl_rdata : df_rdata;
            pvalid_in = 1'b1;
            fn_we     = fok_ff;
            state_in  = S_DONE;
         end
         S_DONE: begin
            rvalid_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         mode_ff   <= 1'b1;
         lfsr_ff   <= pfrr_pkg::LFSR_SEED;
         defcnt_ff <= '0;
         for (int i = 0; i < DEST_ENTRIES; i++) begin
            dcnt_ff[i] <= '0;
         end
         dused_ff  <= '0;
         fused_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         lfsr_ff   <= lfsr_in;
         defcnt_ff <= defcnt_in;
         dcnt_ff   <= dcnt_in;
         dused_ff  <= dused_in;
         fused_ff  <= fused_in;
         rvalid_ff <= rvalid_in;
      end
      op_ff     <= op_in;
      path_ff   <= path_in;
      weight_ff <= weight_in;
      dest_ff   <= dest_in;
      key_ff    <= key_in;
      dscan_ff  <= dscan_in;
      dhit_ff   <= dhit_in;
      didx_ff   <= didx_in;
      dfok_ff   <= dfok_in;
      dfree_ff  <= dfree_in;
      fscan_ff  <= fscan_in;
      fhit_ff   <= fhit_in;
      fidx_ff   <= fidx_in;
      ffok_ff   <= ffok_in;
      ffree_ff  <= ffree_in;
      fok_ff    <= fok_in;
      lsel_ff   <= lsel_in;
      wcnt_ff   <= wcnt_in;
      cp_ff     <= cp_in;
      k_ff      <= k_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      pvalid_ff <= pvalid_in;
      apath_ff  <= apath_in;
   end

   assign busy              = state_ff != S_IDLE;
   assign rsp_valid         = rvalid_ff;
   assign rsp_status        = status_ff;
   assign rsp_path_valid    = pvalid_ff;
   assign rsp_assigned_path = apath_ff;

`ifndef SYNTHESIS
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_default_count: assert property (@(posedge clock) disable iff (reset)
      defcnt_ff <= CW'(PATH_SLOTS))
      else $error("default list count beyond capacity");

   a_path_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_path_valid) |->
         (rsp_status == pfrr_pkg::ST_OK || rsp_status == pfrr_pkg::ST_FULL))
      else $error("path given with an error status");
`endif

endmodule

/* design/pfrr_ram.sv */
module pfrr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

/* design/pfrr_mod.sv */
module pfrr_mod #(
   parameter int CW = 7,
   parameter int IW = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [31:0]   dividend,
   input  logic [CW-1:0] divisor,
   output logic          done,
   output logic [IW-1:0] remainder
);

   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [31:0]   a_ff, a_in;
   logic [CW-1:0] d_ff, d_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [CW:0]   trial;

   assign trial = {rem_ff, a_ff[31]};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      d_in    = d_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = 6'd32;
         a_in   = dividend;
         d_in   = divisor;
         rem_in = '0;
      end else if (run_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            rem_in = CW'(trial - {1'b0, d_ff});
         end else begin
            rem_in = CW'(trial);
         end
         a_in   = {a_ff[30:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = IW'(rem_ff);

endmodule
